[rtl/core/cal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants of the cursor array list
// Field widths, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package cal_pkg;

   localparam int DEPTH_DEFAULT        = 1024;
   localparam int ELEMENT_BITS_DEFAULT = 32;

   localparam int POS_BITS      = 11;
   localparam int KIND_BITS     = 4;
   localparam int STATUS_BITS   = 2;
   localparam int ELEM_OUT_BITS = 32;

   localparam int REQ_DATA_BITS = ((POS_BITS + ELEM_OUT_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ELEM_OUT_BITS + 2 * POS_BITS + 7) / 8) * 8;

   localparam logic [POS_BITS-1:0] CAP_RESET = POS_BITS'(1024);
   localparam logic [POS_BITS-1:0] POS_ZERO  = '0;
   localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] POS_TWO   = POS_BITS'(2);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_READ   = 4'd0,
      KIND_START  = 4'd1,
      KIND_END    = 4'd2,
      KIND_GOTO   = 4'd3,
      KIND_PREV   = 4'd4,
      KIND_NEXT   = 4'd5,
      KIND_APPEND = 4'd6,
      KIND_INSERT = 4'd7,
      KIND_REMOVE = 4'd8,
      KIND_CLEAR  = 4'd9
   } kind_type;

   localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_RD_WAIT,
      SEQ_SHIFT,
      SEQ_INS_WR,
      SEQ_DONE
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/core/cursor_array_list_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_array_list_top: ordered list of element handles with a cursor
// Read, move, append, insert, remove and clear at a cursor over a RAM-held array.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tuser kind; tdata position, element
//   rsp_     out  rsp_tvalid/rsp_tready  tuser status; tdata element, cursor,
//                                        count
//   csr_     in   csr_wr_en              csr_wr_data capacity
//
// A read waits for the registered RAM read data. An insert or remove that
// moves entries shifts one entry per cycle, since the single RAM read and
// write port pair moves one entry at a time; an insert at the end and
// removing the last entry move no entries.
// Reset clears cursor and count and sets capacity to 1024; the RAM is not
// cleared. A new word is accepted while a result waits in the output
// register; a finished result waits for that register to drain.
// ----------------------------------------------------------------------------
module cursor_array_list_top #(
   parameter int DEPTH        = cal_pkg::DEPTH_DEFAULT,
   parameter int ELEMENT_BITS = cal_pkg::ELEMENT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // position [10:0], element_value [42:11], zero pad above
   input  wire logic [cal_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // kind [3:0]
   input  wire logic [cal_pkg::KIND_BITS-1:0]      req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // element_out [31:0], cursor_now [42:32], count_now [53:43], zero pad above
   output logic      [cal_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // status [1:0]
   output logic      [cal_pkg::STATUS_BITS-1:0]    rsp_tuser,
   input  wire logic                               csr_wr_en,
   input  wire logic [cal_pkg::POS_BITS-1:0]       csr_wr_data
);
   import cal_pkg::*;

   localparam int ADDR_BITS = $clog2(DEPTH);

   seq_state_type state_ff, state_in;

   logic [KIND_BITS-1:0]     kind_ff, kind_in;
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [ELEM_OUT_BITS-1:0] val_ff, val_in;
   logic [POS_BITS-1:0]      cursor_ff, cursor_in;
   logic [POS_BITS-1:0]      count_ff, count_in;
   logic [POS_BITS-1:0]      cap_ff, cap_in;
   logic [ELEMENT_BITS-1:0]  elem_ff, elem_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic [POS_BITS-1:0]      src_ff, src_in;
   logic [POS_BITS-1:0]      dst_ff, dst_in;
   logic                     issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;

   logic                     req_fire;
   logic                     rsp_load;
   logic                     list_empty;
   logic                     cur_valid;
   logic                     limit_hit;
   logic                     shift_up;
   logic                     rm_shift;
   logic [POS_BITS-1:0]      last_src;
   logic [POS_BITS-1:0]      last_dst;

   logic                     ram_we;
   logic [POS_BITS-1:0]      wr_idx;
   logic [ELEMENT_BITS-1:0]  wr_data;
   logic [POS_BITS-1:0]      rd_idx;
   logic [ELEMENT_BITS-1:0]  rd_data;

   cal_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_BITS'(wr_idx)),
      .wr_data (wr_data),
      .rd_addr (ADDR_BITS'(rd_idx)),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == SEQ_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Shared decode of the list state for the latched operation.
   always_comb begin
      list_empty = (count_ff == POS_ZERO);
      cur_valid  = (cursor_ff < count_ff);
      limit_hit  = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= 32'(DEPTH));
      shift_up   = (kind_ff == KIND_INSERT);
      rm_shift   = !list_empty && (cursor_ff < (count_ff - POS_ONE));
      // Insert walks down from the top entry; remove walks up to the top.
      last_src   = shift_up ? cursor_ff : (count_ff - POS_ONE);
      last_dst   = shift_up ? (cursor_ff + POS_ONE) : (count_ff - POS_TWO);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            unique case (kind_ff)
               KIND_READ, KIND_REMOVE: begin
                  priority if (list_empty || !cur_valid) begin
                     state_in = SEQ_DONE;
                  end else begin
                     state_in = SEQ_RD_WAIT;
                  end
               end
               KIND_INSERT: begin
                  priority if (limit_hit || (cursor_ff >= count_ff)) begin
                     state_in = SEQ_DONE;
                  end else begin
                     state_in = SEQ_SHIFT;
                  end
               end
               default: begin
                  state_in = SEQ_DONE;
               end
            endcase
         end
         SEQ_RD_WAIT: begin
            if ((kind_ff == KIND_REMOVE) && rm_shift) begin
               state_in = SEQ_SHIFT;
            end else begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_SHIFT: begin
            if (pend_ff && (dst_ff == last_dst)) begin
               state_in = shift_up ? SEQ_INS_WR : SEQ_DONE;
            end
         end
         SEQ_INS_WR: begin
            state_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            if (rsp_load) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      elem_in       = elem_ff;
      status_in     = status_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      wr_idx        = dst_ff;
      wr_data       = rd_data;
      rd_idx        = src_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               kind_in = req_tuser;
               pos_in  = req_tdata[POS_BITS-1:0];
               val_in  = req_tdata[POS_BITS +: ELEM_OUT_BITS];
            end
         end
         SEQ_EXEC: begin
            elem_in   = '0;
            status_in = STAT_OK;
            unique case (kind_ff)
               KIND_READ, KIND_REMOVE: begin
                  priority if (list_empty) begin
                     status_in = STAT_EMPTY;
                  end else if (!cur_valid) begin
                     status_in = STAT_RANGE;
                  end else begin
                     rd_idx = cursor_ff;
                  end
               end
               KIND_START: begin
                  cursor_in = POS_ZERO;
               end
               KIND_END: begin
                  cursor_in = list_empty ? POS_ZERO : (count_ff - POS_ONE);
               end
               KIND_GOTO: begin
                  if (pos_ff > count_ff) begin
                     status_in = STAT_RANGE;
                  end else begin
                     cursor_in = pos_ff;
                  end
               end
               KIND_PREV: begin
                  if (cursor_ff != POS_ZERO) begin
                     cursor_in = cursor_ff - POS_ONE;
                  end
               end
               KIND_NEXT: begin
                  if (rm_shift) begin
                     cursor_in = cursor_ff + POS_ONE;
                  end
               end
               KIND_APPEND: begin
                  if (limit_hit) begin
                     status_in = STAT_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     wr_idx   = count_ff;
                     wr_data  = ELEMENT_BITS'(val_ff);
                     count_in = count_ff + POS_ONE;
                  end
               end
               KIND_INSERT: begin
                  priority if (limit_hit) begin
                     status_in = STAT_FULL;
                  end else if (cursor_ff > count_ff) begin
                     status_in = STAT_RANGE;
                  end else if (cursor_ff == count_ff) begin
                     ram_we   = 1'b1;
                     wr_idx   = cursor_ff;
                     wr_data  = ELEMENT_BITS'(val_ff);
                     count_in = count_ff + POS_ONE;
                  end else begin
                     src_in   = count_ff - POS_ONE;
                     dst_in   = count_ff;
                     issue_in = 1'b1;
                     pend_in  = 1'b0;
                  end
               end
               KIND_CLEAR: begin
                  cursor_in = POS_ZERO;
                  count_in  = POS_ZERO;
               end
               default: begin
               end
            endcase
         end
         SEQ_RD_WAIT: begin
            elem_in = rd_data;
            if (kind_ff == KIND_REMOVE) begin
               if (rm_shift) begin
                  src_in   = cursor_ff + POS_ONE;
                  dst_in   = cursor_ff;
                  issue_in = 1'b1;
                  pend_in  = 1'b0;
               end else begin
                  count_in = count_ff - POS_ONE;
               end
            end
         end
         SEQ_SHIFT: begin
            // Reads run one entry ahead of writes through the registered port.
            rd_idx  = src_ff;
            pend_in = issue_ff;
            if (issue_ff) begin
               src_in   = shift_up ? (src_ff - POS_ONE) : (src_ff + POS_ONE);
               issue_in = (src_ff != last_src);
            end
            if (pend_ff) begin
               ram_we  = 1'b1;
               wr_idx  = dst_ff;
               wr_data = rd_data;
               dst_in  = shift_up ? (dst_ff - POS_ONE) : (dst_ff + POS_ONE);
               if ((dst_ff == last_dst) && !shift_up) begin
                  count_in = count_ff - POS_ONE;
               end
            end
         end
         SEQ_INS_WR: begin
            ram_we   = 1'b1;
            wr_idx   = cursor_ff;
            wr_data  = ELEMENT_BITS'(val_ff);
            count_in = count_ff + POS_ONE;
         end
         SEQ_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = RSP_DATA_BITS'({count_ff, cursor_ff,
                                               ELEM_OUT_BITS'(elem_ff)});
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cursor_ff    <= POS_ZERO;
         count_ff     <= POS_ZERO;
         cap_ff       <= CAP_RESET;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      elem_ff       <= elem_in;
      status_ff     <= status_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_count_fits : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count exceeds the array depth");

   a_cursor_in_list : assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor lies beyond the entry count");

   a_write_in_list : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (wr_idx <= count_ff))
      else $error("RAM write lands beyond the end of the list");

   a_done_after_load : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (state_ff == SEQ_IDLE)))
      else $error("loaded result did not appear on the response channel");

endmodule

`default_nettype wire

[rtl/core/cal_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
